[rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sparse set table
// Holds the command, status and state codes, the controller/datapath
// interface structs and the default sizing constants.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Default sizing
  localparam int DEF_ENTITIES  = 256;
  localparam int DEF_ELEM_BITS = 32;

  // Fixed field widths on the stream ports
  localparam int CMD_W    = 2;
  localparam int EID_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int LIVE_W   = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_READ
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the input transfer, start lookups
    logic look_rd;  // fetch the entity's element
    logic commit;   // apply the update and load the result
    logic emit_rd;  // load the result of an element read
  } sst_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_read;  // current op is a successful element read
    logic out_free;   // result register can take a new result
  } sst_stat_t;

endpackage

[rtl/sst_ctrl.sv]
// ----------------------------------------------------------------------------
// sst_ctrl: operation sequencer
// Accepts one item, steps through lookup and optional element fetch, and
// hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module sst_ctrl
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sst_stat_t stat,
  output sst_ctl_t  ctl
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.need_read) begin
          ctl.look_rd = 1'b1;
          state_nxt   = S_READ;
        end else if (stat.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          ctl.emit_rd = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sst_dp.sv]
// ----------------------------------------------------------------------------
// sst_dp: sparse set datapath
// Presence bits, live count, the entity-to-slot, slot-to-owner and element
// memories, and the result register.
// ----------------------------------------------------------------------------
module sst_dp
  import sst_pkg::*;
#(
  parameter int ENTITIES  = DEF_ENTITIES,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sst_ctl_t               ctl,
  output sst_stat_t              stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Only ids that fit the id field can ever be present
  localparam int DEPTH = (ENTITIES < 256) ? ENTITIES : 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Input field split
  logic [CMD_W-1:0]  in_cmd;
  logic [EID_W-1:0]  in_eid;
  logic [DATA_W-1:0] in_elem;
  logic [63:0]       in_wide;
  assign in_cmd  = in_tdata[CMD_W-1:0];
  assign in_eid  = in_tdata[CMD_W +: EID_W];
  assign in_elem = in_tdata[CMD_W+EID_W +: DATA_W];
  assign in_wide = 64'(in_elem);

  // Latched item
  cmd_t                 cmd_r;
  logic [EID_W-1:0]     eid_r;
  logic [ELEM_BITS-1:0] data_r;

  // Control state
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Memories
  logic [IDX_W-1:0]     ent_slot_mem [DEPTH];
  logic [IDX_W-1:0]     owner_mem    [DEPTH];
  logic [ELEM_BITS-1:0] elem_mem     [DEPTH];

  // Registered read data
  logic [IDX_W-1:0]     slot_q;
  logic [IDX_W-1:0]     owner_q;
  logic [ELEM_BITS-1:0] elem_q;

  logic [IDX_W-1:0] in_eid_idx;
  logic [IDX_W-1:0] eid_idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] cnt_idx;
  assign in_eid_idx = IDX_W'(in_eid);
  assign eid_idx    = IDX_W'(eid_r);
  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign cnt_idx    = IDX_W'(count_r);

  // Item latch
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      eid_r  <= in_eid;
      data_r <= in_wide[ELEM_BITS-1:0];
    end
  end

  // Operation decode
  logic id_ok, present, live_ok, full;
  logic alloc_ok, free_ok, wr_ok;
  assign id_ok    = {1'b0, eid_r} < 9'(DEPTH);
  assign present  = id_ok && valid_r[eid_idx];
  assign live_ok  = present && (count_r != '0);
  assign full     = count_r >= CNT_W'(DEPTH);
  assign alloc_ok = id_ok && (cmd_r == CMD_ALLOC) && !present && !full;
  assign free_ok  = (cmd_r == CMD_FREE) && live_ok;
  assign wr_ok    = (cmd_r == CMD_WRITE) && live_ok;

  assign stat.need_read = (cmd_r == CMD_READ) && live_ok;

  // Memory write ports
  logic                 es_we, ow_we, el_we;
  logic [IDX_W-1:0]     es_wa, es_wd, ow_wa, ow_wd, el_wa;
  logic [ELEM_BITS-1:0] el_wd;
  logic [IDX_W-1:0]     el_ra;

  always_comb begin
    es_we = ctl.commit && (alloc_ok || free_ok);
    es_wa = alloc_ok ? eid_idx : owner_q;
    es_wd = alloc_ok ? cnt_idx : slot_q;
    ow_we = ctl.commit && (alloc_ok || free_ok);
    ow_wa = alloc_ok ? cnt_idx : slot_q;
    ow_wd = alloc_ok ? eid_idx : owner_q;
    el_we = ctl.commit && (alloc_ok || free_ok || wr_ok);
    el_wa = alloc_ok ? cnt_idx : slot_q;
    el_wd = free_ok ? elem_q : data_r;
    // last slot on lookup, entity's own slot on fetch
    el_ra = ctl.capture ? last_idx : slot_q;
  end

  // Entity-to-slot memory
  always_ff @(posedge clk) begin
    if (es_we) begin
      ent_slot_mem[es_wa] <= es_wd;
    end
    if (ctl.capture) begin
      slot_q <= ent_slot_mem[in_eid_idx];
    end
  end

  // Slot-to-owner memory
  always_ff @(posedge clk) begin
    if (ow_we) begin
      owner_mem[ow_wa] <= ow_wd;
    end
    if (ctl.capture) begin
      owner_q <= owner_mem[last_idx];
    end
  end

  // Element memory
  always_ff @(posedge clk) begin
    if (el_we) begin
      elem_mem[el_wa] <= el_wd;
    end
    if (ctl.capture || ctl.look_rd) begin
      elem_q <= elem_mem[el_ra];
    end
  end

  // Presence bits and live count
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (ctl.commit && alloc_ok) begin
      valid_nxt[eid_idx] = 1'b1;
      count_nxt          = count_r + CNT_W'(1);
    end else if (ctl.commit && free_ok) begin
      valid_nxt[eid_idx] = 1'b0;
      count_nxt          = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // Result formation
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [63:0]      elem_wide;
  assign elem_wide = 64'(elem_q);

  always_comb begin
    res_status = STAT_ABSENT;
    res_slot   = '0;
    if (!id_ok) begin
      res_status = STAT_ABSENT;
    end else if (cmd_r == CMD_ALLOC) begin
      if (present) begin
        res_status = STAT_PRESENT;
        res_slot   = slot_q;
      end else if (!full) begin
        res_status = STAT_OK;
        res_slot   = cnt_idx;
      end
    end else if (live_ok) begin
      res_status = STAT_OK;
      res_slot   = free_ok ? '0 : slot_q;
    end
  end

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit || ctl.emit_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data_r <= OUT_TDATA_W'({LIVE_W'(count_nxt), SLOT_W'(res_slot),
                                  DATA_W'(0), res_status});
    end else if (ctl.emit_rd) begin
      out_data_r <= OUT_TDATA_W'({LIVE_W'(count_r), SLOT_W'(slot_q),
                                  elem_wide[DATA_W-1:0], STAT_OK});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/sparse_set_table_top.sv]
// A result is loaded from the lookup state, or from the read state for a read,
// once the result register is free. One item at a time: no new input is taken
//   until it is loaded, after the registered slot lookup and any element fetch.
// The next input is taken while the previous result still waits on out_tready.
// Reset (rst_n low, synchronous) clears presence bits, live count and control;
//   the slot and element memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// sparse_set_table_top: sparse set with swap-remove
// Maps entity ids to packed dense slots; alloc, free, read and write of
// per-entity elements over stream ports.
// ----------------------------------------------------------------------------
module sparse_set_table_top
  import sst_pkg::*;
#(
  parameter int ENTITIES  = DEF_ENTITIES,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd[1:0], eid[9:2], elem_data[41:10], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], read_data[33:2], slot_index[41:34], live_count[50:42], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  sst_ctl_t  ctl;
  sst_stat_t stat;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  sst_dp #(
    .ENTITIES  (ENTITIES),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.capture, ctl.look_rd, ctl.commit, ctl.emit_rd}))
    else $error("multiple datapath commands");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit || ctl.emit_rd) |-> stat.out_free)
    else $error("result overwritten");

  // No second item is taken while one is in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted during work");

  // The lookup cycle moves on unless the result register is held
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> (ctl.commit || ctl.look_rd || !stat.out_free))
    else $error("lookup stalled without cause");

endmodule

[verif/tb_sparse_set_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_set_table_top: self-checking bench for the sparse set table
// Sends alloc/free/read/write commands over the input stream in random
// bursts. Each accepted command goes through a local model of the swap-remove
// table, and each result transfer is checked field by field against the
// oldest expected result. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_sparse_set_table_top;
  import sst_pkg::*;

  localparam int N_ENT = DEF_ENTITIES;

  // One command and one result, at the port widths
  typedef struct {
    cmd_t              cmd;
    logic [EID_W-1:0]  eid;
    logic [DATA_W-1:0] elem_data;
  } table_op_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] read_data;
    logic [SLOT_W-1:0] slot_index;
    logic [LIVE_W-1:0] live_count;
  } table_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sparse_set_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #10 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("tb_sparse_set_table_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table model: presence, entity->slot, slot->owner, dense elements, count
  // --------------------------------------------------------------------------
  logic              mdl_present [N_ENT];
  logic [SLOT_W-1:0] mdl_slot    [N_ENT];
  logic [EID_W-1:0]  mdl_owner   [N_ENT];
  logic [DATA_W-1:0] mdl_elem    [N_ENT];
  logic [LIVE_W-1:0] mdl_live = '0;

  initial begin
    for (int i = 0; i < N_ENT; i++) mdl_present[i] = 1'b0;
  end

  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t r;
    int unsigned   e;
    int unsigned   idx;
    int unsigned   last;
    int unsigned   owner;
    r.status     = STAT_OK;
    r.read_data  = '0;
    r.slot_index = '0;
    e = 32'(op.eid);
    if (op.cmd == CMD_ALLOC) begin
      if (mdl_present[e]) begin
        r.status     = STAT_PRESENT;
        r.slot_index = mdl_slot[e];
      end else if (mdl_live >= N_ENT) begin
        r.status = STAT_ABSENT;
      end else begin
        idx            = 32'(mdl_live);
        mdl_slot[e]    = SLOT_W'(idx);
        mdl_owner[idx] = EID_W'(e);
        mdl_elem[idx]  = op.elem_data;
        mdl_present[e] = 1'b1;
        mdl_live       = mdl_live + 1'b1;
        r.slot_index   = SLOT_W'(idx);
      end
    end else if (!mdl_present[e] || mdl_live == 0) begin
      r.status = STAT_ABSENT;
    end else begin
      idx = 32'(mdl_slot[e]);
      case (op.cmd)
        CMD_FREE: begin
          // swap-remove: last element moves into the freed slot
          last            = 32'(mdl_live) - 1;
          owner           = 32'(mdl_owner[last]);
          mdl_elem[idx]   = mdl_elem[last];
          mdl_owner[idx]  = EID_W'(owner);
          mdl_slot[owner] = SLOT_W'(idx);
          mdl_present[e]  = 1'b0;
          mdl_live        = mdl_live - 1'b1;
        end
        CMD_READ: begin
          r.read_data  = mdl_elem[idx];
          r.slot_index = SLOT_W'(idx);
        end
        default: begin
          mdl_elem[idx] = op.elem_data;
          r.slot_index  = SLOT_W'(idx);
        end
      endcase
    end
    r.live_count = mdl_live;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus build: shadow presence lets the generator aim at live entities
  // --------------------------------------------------------------------------
  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  int            n_ops = 0;
  int            n_accepted = 0;
  int            fail_count = 0;

  logic gen_present [N_ENT];
  int   gen_live = 0;

  task automatic add_op(cmd_t cmd, int id, logic [DATA_W-1:0] data);
    table_op_t op;
    op.cmd       = cmd;
    op.eid       = EID_W'(id);
    op.elem_data = data;
    pending_ops.push_back(op);
    n_ops++;
    if (cmd == CMD_ALLOC && !gen_present[id]) begin
      gen_present[id] = 1'b1;
      gen_live++;
    end else if (cmd == CMD_FREE && gen_present[id]) begin
      gen_present[id] = 1'b0;
      gen_live--;
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom();
  endfunction

  function automatic int pick_absent();
    int id;
    do id = $urandom_range(0, N_ENT - 1); while (gen_present[id]);
    return id;
  endfunction

  function automatic int pick_present();
    int id;
    do id = $urandom_range(0, N_ENT - 1); while (!gen_present[id]);
    return id;
  endfunction

  // Random command on a live entity, or noise when none is live
  task automatic add_live_access(bit allow_free);
    int unsigned sel;
    if (gen_live == 0) begin
      add_op(cmd_t'($urandom_range(0, 3)), $urandom_range(0, N_ENT - 1), rand_elem());
    end else begin
      sel = $urandom_range(0, allow_free ? 2 : 1);
      case (sel)
        0:       add_op(CMD_READ, pick_present(), rand_elem());
        1:       add_op(CMD_WRITE, pick_present(), rand_elem());
        default: add_op(CMD_FREE, pick_present(), rand_elem());
      endcase
    end
  endtask

  task automatic build_stimulus();
    int unsigned sel;
    for (int i = 0; i < N_ENT; i++) gen_present[i] = 1'b0;

    // Directed: empty table, id and data extremes, duplicate alloc,
    // swap-remove from the middle, from the last slot and from slot zero
    add_op(CMD_READ,  0,   32'h1234_5678);
    add_op(CMD_FREE,  0,   32'h0);
    add_op(CMD_WRITE, 255, 32'hFFFF_FFFF);
    add_op(CMD_ALLOC, 0,   32'h0000_0000);
    add_op(CMD_ALLOC, 255, 32'hFFFF_FFFF);
    add_op(CMD_ALLOC, 0,   32'h1234_5678);
    add_op(CMD_READ,  0,   32'h0);
    add_op(CMD_READ,  255, 32'h0);
    add_op(CMD_WRITE, 255, 32'h0000_0000);
    add_op(CMD_WRITE, 0,   32'hFFFF_FFFF);
    add_op(CMD_READ,  255, 32'h0);
    add_op(CMD_READ,  0,   32'h0);
    add_op(CMD_ALLOC, 170, 32'hA5A5_A5A5);
    add_op(CMD_ALLOC, 85,  32'h5A5A_5A5A);
    add_op(CMD_FREE,  255, 32'h0);
    add_op(CMD_READ,  85,  32'h0);
    add_op(CMD_FREE,  170, 32'h0);
    add_op(CMD_READ,  170, 32'h0);
    add_op(CMD_FREE,  0,   32'h0);
    add_op(CMD_READ,  85,  32'h0);
    add_op(CMD_FREE,  85,  32'h0);
    add_op(CMD_READ,  85,  32'h0);
    add_op(CMD_FREE,  85,  32'h0);
    add_op(CMD_ALLOC, 1,   32'h0000_0001);
    add_op(CMD_ALLOC, 254, 32'h8000_0000);

    // Fill until every entity holds a slot
    while (gen_live < N_ENT) begin
      sel = $urandom_range(0, 19);
      if (sel < 17)       add_op(CMD_ALLOC, pick_absent(), rand_elem());
      else if (sel < 19)  add_live_access(1'b0);
      else                add_op(cmd_t'($urandom_range(0, 3)), $urandom_range(0, N_ENT - 1),
                                 rand_elem());
    end

    // Full table: duplicate allocs and accesses, then drain with mixed traffic
    repeat (6) add_op(CMD_ALLOC, pick_present(), rand_elem());
    repeat (80) begin
      sel = $urandom_range(0, 19);
      if (sel < 7)                         add_op(CMD_FREE, (gen_live > 0) ? pick_present() :
                                                  $urandom_range(0, N_ENT - 1), rand_elem());
      else if (sel < 12)                   add_live_access(1'b0);
      else if (sel < 15 && gen_live < N_ENT) add_op(CMD_ALLOC, pick_absent(), rand_elem());
      else if (sel < 17 && gen_live > 0)   add_op(CMD_ALLOC, pick_present(), rand_elem());
      else                                 add_op(cmd_t'($urandom_range(0, 3)),
                                                  $urandom_range(0, N_ENT - 1), rand_elem());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, wait for all transfers to drain, report
  // --------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (n_accepted < n_ops || expected_results.size() != 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb_sparse_set_table_top passed");
    end else begin
      $display("tb_sparse_set_table_top failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  table_op_t     tx_op;
  table_result_t tx_pred;
  int            burst_left = 4;
  int            gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // transfer accepted: predict its result
      if (in_tvalid && in_tready) begin
        tx_pred = apply_table_op(tx_op);
        expected_results.push_back(tx_pred);
        n_accepted++;
      end
      // hold an offered item until it is taken
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          tx_op = pending_ops.pop_front();
          in_tdata  <= {6'b0, tx_op.elem_data, tx_op.eid, tx_op.cmd};
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer, drives the receiver stall pattern
  // --------------------------------------------------------------------------
  table_result_t rx_exp;
  int            rx_mode = 0;
  int            rx_mode_left = 40;
  int            rx_run_left = 0;
  logic          rx_level = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result: tdata %h", out_tdata);
          fail_count++;
        end else begin
          rx_exp = expected_results.pop_front();
          if (out_tdata[1:0] !== rx_exp.status) begin
            $error("status mismatch: expected %0d, got %0d", rx_exp.status, out_tdata[1:0]);
            fail_count++;
          end
          if (out_tdata[33:2] !== rx_exp.read_data) begin
            $error("read_data mismatch: expected %h, got %h", rx_exp.read_data,
                   out_tdata[33:2]);
            fail_count++;
          end
          if (out_tdata[41:34] !== rx_exp.slot_index) begin
            $error("slot_index mismatch: expected %0d, got %0d", rx_exp.slot_index,
                   out_tdata[41:34]);
            fail_count++;
          end
          if (out_tdata[50:42] !== rx_exp.live_count) begin
            $error("live_count mismatch: expected %0d, got %0d", rx_exp.live_count,
                   out_tdata[50:42]);
            fail_count++;
          end
        end
      end

      // stall pattern: always ready, choppy, or long stalls
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 80);
        rx_run_left  = 0;
      end else begin
        rx_mode_left--;
      end
      if (rx_run_left == 0) begin
        case (rx_mode)
          0: begin
            rx_level    = 1'b1;
            rx_run_left = $urandom_range(10, 40);
          end
          1: begin
            rx_level    = 1'($urandom_range(0, 1));
            rx_run_left = $urandom_range(1, 3);
          end
          default: begin
            rx_level    = ~rx_level;
            rx_run_left = rx_level ? $urandom_range(1, 2) : $urandom_range(4, 16);
          end
        endcase
      end else begin
        rx_run_left--;
      end
      out_tready <= rx_level;
    end
  end

endmodule

[filelist.f]
rtl/sst_pkg.sv
rtl/sst_ctrl.sv
rtl/sst_dp.sv
rtl/sparse_set_table_top.sv
verif/tb_sparse_set_table_top.sv
